// ===== hdl/priority_preemptive_task_scheduler_assert.svh =====
// Assertion macros for the preemptive priority task scheduler.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef PRIORITY_PREEMPTIVE_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_PREEMPTIVE_TASK_SCHEDULER_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define PPTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scheduler port check failed");

// Same, with a fixed message for result payload rules.
`define PPTS_ASSERT_OUT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scheduler result payload check failed");

`endif

// ===== hdl/ppts_pkg.sv =====
// Package for the preemptive priority task scheduler.
// Holds the slot entry type, code constants and the priority mapping; no dependencies.
`default_nettype none
package ppts_pkg;

  typedef struct packed {
    logic [7:0]  ident;
    logic [7:0]  prio;
    logic [2:0]  policy;
    logic [23:0] remaining;
    logic [31:0] wait_ms;
    logic [31:0] start_ms;
    logic        started;
    logic [15:0] preempts;
  } slot_entry_t;

  localparam logic       ACT_ADD  = 1'b0;
  localparam logic       ACT_TICK = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOTHING   = 2'd2;

  localparam logic [2:0] POL_FIFO     = 3'd0;
  localparam logic [2:0] POL_RR       = 3'd1;
  localparam logic [2:0] POL_TS       = 3'd2;
  localparam logic [2:0] POL_IDLE     = 3'd3;
  localparam logic [2:0] POL_DEADLINE = 3'd4;

  localparam logic [1:0] CLS_FG       = 2'd0;
  localparam logic [1:0] CLS_BG       = 2'd1;
  localparam logic [1:0] CLS_DAEMON   = 2'd2;
  localparam logic [1:0] CLS_EMPTY    = 2'd3;

  localparam logic [15:0] SLICE_RESET = 16'd100;
  localparam logic [15:0] PREEMPT_MAX = 16'hFFFF;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Map nice, policy and class to a priority in 0..139.
  function automatic logic [7:0] calc_prio(input logic [5:0] nice, input logic [2:0] pol,
                                           input logic [1:0] cls);
    logic signed [9:0] n;
    logic signed [9:0] p;
    n = {{4{nice[5]}}, nice};
    case (pol)
      POL_FIFO, POL_RR: p = 10'sd99 - (n + 10'sd20);
      POL_IDLE:         p = 10'sd139;
      POL_DEADLINE:     p = 10'sd0;
      default:          p = 10'sd120 + n;
    endcase
    case (cls)
      CLS_BG:     p = p + 10'sd5;
      CLS_DAEMON: p = p - 10'sd3;
      CLS_EMPTY:  p = 10'sd139;
      default:    p = p;
    endcase
    if (p < 10'sd0) p = 10'sd0;
    if (p > 10'sd139) p = 10'sd139;
    return p[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/priority_preemptive_task_scheduler.sv =====
// An add runs a free-slot scan, a slot write and an ordered insert that moves list entries
// up one by one; a tick runs the wait walk, dispatch, run and priority compare, plus an
// ordered insert and a fresh dispatch when the current task is requeued.
// Throughput: one item at a time; in_ready is low from the transfer until the result loads,
// which waits while the previous result has not been taken.
// Reset (rst_n low, synchronous): empty table and ready list, no current task, clock zero.
`default_nettype none
module priority_preemptive_task_scheduler
  import ppts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_action,
  input  wire  [7:0]  in_task_id,
  input  wire  [5:0]  in_nice,
  input  wire  [2:0]  in_policy,
  input  wire  [1:0]  in_task_class,
  input  wire  [23:0] in_burst_ms,
  input  wire  [15:0] in_tick_ms,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_status,
  output logic        out_running_valid,
  output logic [7:0]  out_running_id,
  output logic        out_preempted,
  output logic        out_done_valid,
  output logic [7:0]  out_done_id,
  output logic [31:0] out_done_wait,
  output logic [31:0] out_done_response,
  output logic [31:0] out_done_turnaround,
  output logic [15:0] out_done_preemptions
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = SW + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_SCAN = 4'd1;
  localparam logic [3:0] S_ADD_WR   = 4'd2;
  localparam logic [3:0] S_INS_A    = 4'd3;
  localparam logic [3:0] S_INS_B    = 4'd4;
  localparam logic [3:0] S_INS_C    = 4'd5;
  localparam logic [3:0] S_WAIT     = 4'd6;
  localparam logic [3:0] S_DISP_RD  = 4'd7;
  localparam logic [3:0] S_DISP_WR  = 4'd8;
  localparam logic [3:0] S_RUN_RD   = 4'd9;
  localparam logic [3:0] S_RUN_EX   = 4'd10;
  localparam logic [3:0] S_RUN_CMP  = 4'd11;
  localparam logic [3:0] S_OUT_RD   = 4'd12;
  localparam logic [3:0] S_OUT_WR   = 4'd13;

  // Ready-list position to ring address: head plus offset, wrapped once.
  function automatic logic [SW-1:0] phys(input logic [SW-1:0] hd, input logic [CW-1:0] j);
    logic [CW-1:0] s;
    s = {1'b0, hd} + j;
    if (s >= CW'(MAX_TASKS)) s = s - CW'(MAX_TASKS);
    return s[SW-1:0];
  endfunction

  // Slot table and ready ring: one write and one registered read port each.
  slot_entry_t slot_mem [MAX_TASKS];
  logic [SW-1:0] ord_mem [MAX_TASKS];

  slot_entry_t   slot_rdata_r, slot_wdata;
  logic          slot_we, slot_re;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] ord_rdata_r, ord_wdata, ord_waddr, ord_raddr;
  logic          ord_we, ord_re;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rdata_r <= slot_mem[slot_raddr];
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    if (ord_re) ord_rdata_r <= ord_mem[ord_raddr];
  end

  // Control state
  logic [3:0]    state_r, state_nxt;
  logic          used_r [MAX_TASKS];
  logic          used_nxt [MAX_TASKS];
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [31:0]   slice_used_r, slice_used_nxt;
  logic [31:0]   clock_r, clock_nxt;
  logic [15:0]   slice_ms_r, slice_ms_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [SW-1:0] pend_addr_r, pend_addr_nxt;
  logic          requeue_r, requeue_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Item and work registers
  logic          act_r, act_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [7:0]    prio_r, prio_nxt;
  logic [2:0]    pol_r, pol_nxt;
  logic [23:0]   burst_r, burst_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [SW-1:0] sel_r, sel_nxt;
  logic [7:0]    ins_prio_r, ins_prio_nxt;
  slot_entry_t   cur_e_r, cur_e_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          pre_r, pre_nxt;
  logic          dv_r, dv_nxt;
  logic [7:0]    did_r, did_nxt;
  logic [31:0]   dwait_r, dwait_nxt, dresp_r, dresp_nxt, dturn_r, dturn_nxt;
  logic [15:0]   dpre_r, dpre_nxt;

  // Result register
  logic [1:0]    o_status_r, o_status_nxt;
  logic          o_rv_r, o_rv_nxt, o_pre_r, o_pre_nxt, o_dv_r, o_dv_nxt;
  logic [7:0]    o_rid_r, o_rid_nxt, o_did_r, o_did_nxt;
  logic [31:0]   o_dwait_r, o_dwait_nxt, o_dresp_r, o_dresp_nxt, o_dturn_r, o_dturn_nxt;
  logic [15:0]   o_dpre_r, o_dpre_nxt;

  // Run step temporaries
  slot_entry_t   run_e;
  logic [23:0]   ex;
  logic          sliced, better;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    cur_nxt        = cur_r;
    cur_valid_nxt  = cur_valid_r;
    slice_used_nxt = slice_used_r;
    clock_nxt      = clock_r;
    slice_ms_nxt   = (cfg_valid) ? cfg_data : slice_ms_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    requeue_nxt    = requeue_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    act_nxt        = act_r;
    id_nxt         = id_r;
    prio_nxt       = prio_r;
    pol_nxt        = pol_r;
    burst_nxt      = burst_r;
    tick_nxt       = tick_r;
    sel_nxt        = sel_r;
    ins_prio_nxt   = ins_prio_r;
    cur_e_nxt      = cur_e_r;
    status_nxt     = status_r;
    pre_nxt        = pre_r;
    dv_nxt         = dv_r;
    did_nxt        = did_r;
    dwait_nxt      = dwait_r;
    dresp_nxt      = dresp_r;
    dturn_nxt      = dturn_r;
    dpre_nxt       = dpre_r;
    o_status_nxt   = o_status_r;
    o_rv_nxt       = o_rv_r;
    o_rid_nxt      = o_rid_r;
    o_pre_nxt      = o_pre_r;
    o_dv_nxt       = o_dv_r;
    o_did_nxt      = o_did_r;
    o_dwait_nxt    = o_dwait_r;
    o_dresp_nxt    = o_dresp_r;
    o_dturn_nxt    = o_dturn_r;
    o_dpre_nxt     = o_dpre_r;
    slot_we        = 1'b0;
    slot_waddr     = '0;
    slot_wdata     = slot_rdata_r;
    slot_re        = 1'b0;
    slot_raddr     = '0;
    ord_we         = 1'b0;
    ord_waddr      = '0;
    ord_wdata      = '0;
    ord_re         = 1'b0;
    ord_raddr      = '0;

    // Current task after this tick's run, before any preemption.
    run_e = slot_rdata_r;
    ex = ({8'd0, tick_r} < slot_rdata_r.remaining) ? {8'd0, tick_r} : slot_rdata_r.remaining;
    if (!run_e.started) begin
      run_e.started  = 1'b1;
      run_e.start_ms = clock_r;
    end
    run_e.remaining = slot_rdata_r.remaining - ex;
    sliced = ((cur_e_r.policy == POL_RR) || (cur_e_r.policy == POL_TS)) &&
             (slice_used_r >= {16'd0, slice_ms_r});
    better = (count_r != '0) && (slot_rdata_r.prio < cur_e_r.prio);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_action;
          id_nxt      = in_task_id;
          prio_nxt    = calc_prio(in_nice, in_policy, in_task_class);
          pol_nxt     = in_policy;
          burst_nxt   = in_burst_ms;
          tick_nxt    = in_tick_ms;
          status_nxt  = ST_OK;
          pre_nxt     = 1'b0;
          dv_nxt      = 1'b0;
          did_nxt     = '0;
          dwait_nxt   = '0;
          dresp_nxt   = '0;
          dturn_nxt   = '0;
          dpre_nxt    = '0;
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          requeue_nxt = 1'b0;
          state_nxt   = (in_action == ACT_TICK) ? S_WAIT : S_ADD_SCAN;
        end
      end
      // Scan valid bits for the lowest free slot.
      S_ADD_SCAN: begin
        if (!used_r[idx_r[SW-1:0]]) begin
          sel_nxt   = idx_r[SW-1:0];
          state_nxt = S_ADD_WR;
        end else if (idx_r == CW'(MAX_TASKS - 1)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_OUT_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_ADD_WR: begin
        slot_we    = 1'b1;
        slot_waddr = sel_r;
        slot_wdata = '{ident: id_r, prio: prio_r, policy: pol_r, remaining: burst_r,
                       wait_ms: 32'd0, start_ms: 32'd0, started: 1'b0, preempts: 16'd0};
        used_nxt[sel_r] = 1'b1;
        ins_prio_nxt    = prio_r;
        idx_nxt         = count_r;
        state_nxt       = S_INS_A;
      end
      // Ordered insert, walking back from the tail and moving later entries up.
      S_INS_A: begin
        if (idx_r == '0) begin
          ord_we    = 1'b1;
          ord_waddr = head_r;
          ord_wdata = sel_r;
          count_nxt = count_r + 1'b1;
          state_nxt = requeue_r ? S_DISP_RD : S_OUT_RD;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = phys(head_r, idx_r - 1'b1);
          state_nxt = S_INS_B;
        end
      end
      S_INS_B: begin
        slot_re    = 1'b1;
        slot_raddr = ord_rdata_r;
        state_nxt  = S_INS_C;
      end
      S_INS_C: begin
        ord_we    = 1'b1;
        ord_waddr = phys(head_r, idx_r);
        if (slot_rdata_r.prio > ins_prio_r) begin
          ord_wdata = ord_rdata_r;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_INS_A;
        end else begin
          ord_wdata = sel_r;
          count_nxt = count_r + 1'b1;
          state_nxt = requeue_r ? S_DISP_RD : S_OUT_RD;
        end
      end
      // Wait accounting: read one slot per cycle, write it back in the next cycle.
      S_WAIT: begin
        pend_nxt = 1'b0;
        if (idx_r != CW'(MAX_TASKS)) begin
          if (used_r[idx_r[SW-1:0]] && !(cur_valid_r && (cur_r == idx_r[SW-1:0]))) begin
            slot_re       = 1'b1;
            slot_raddr    = idx_r[SW-1:0];
            pend_nxt      = 1'b1;
            pend_addr_nxt = idx_r[SW-1:0];
          end
          idx_nxt = idx_r + 1'b1;
        end
        if (pend_r) begin
          slot_we            = 1'b1;
          slot_waddr         = pend_addr_r;
          slot_wdata.wait_ms = sat_add32(slot_rdata_r.wait_ms, {16'd0, tick_r});
        end
        if ((idx_r == CW'(MAX_TASKS)) && !pend_r) begin
          if (cur_valid_r) begin
            state_nxt = S_RUN_RD;
          end else if (count_r == '0) begin
            status_nxt = ST_NOTHING;
            state_nxt  = S_OUT_RD;
          end else begin
            state_nxt = S_DISP_RD;
          end
        end
      end
      S_DISP_RD: begin
        ord_re    = 1'b1;
        ord_raddr = head_r;
        state_nxt = S_DISP_WR;
      end
      S_DISP_WR: begin
        cur_nxt        = ord_rdata_r;
        head_nxt       = phys(head_r, CW'(1));
        count_nxt      = count_r - 1'b1;
        cur_valid_nxt  = 1'b1;
        slice_used_nxt = '0;
        state_nxt      = requeue_r ? S_OUT_RD : S_RUN_RD;
      end
      S_RUN_RD: begin
        slot_re    = 1'b1;
        slot_raddr = cur_r;
        ord_re     = 1'b1;
        ord_raddr  = head_r;
        state_nxt  = S_RUN_EX;
      end
      // Run the current task; fetch the head entry for the priority compare.
      S_RUN_EX: begin
        slice_used_nxt = sat_add32(slice_used_r, {8'd0, ex});
        if (run_e.remaining == '0) begin
          dv_nxt        = 1'b1;
          did_nxt       = run_e.ident;
          dwait_nxt     = run_e.wait_ms;
          dresp_nxt     = run_e.start_ms;
          dturn_nxt     = sat_add32(clock_r, {8'd0, ex});
          dpre_nxt      = run_e.preempts;
          used_nxt[cur_r] = 1'b0;
          cur_valid_nxt = 1'b0;
          state_nxt     = S_OUT_RD;
        end else begin
          cur_e_nxt  = run_e;
          slot_re    = 1'b1;
          slot_raddr = ord_rdata_r;
          state_nxt  = S_RUN_CMP;
        end
      end
      S_RUN_CMP: begin
        slot_we    = 1'b1;
        slot_waddr = cur_r;
        slot_wdata = cur_e_r;
        if (sliced || better) begin
          if (cur_e_r.preempts != PREEMPT_MAX) begin
            slot_wdata.preempts = cur_e_r.preempts + 1'b1;
          end
          pre_nxt       = 1'b1;
          cur_valid_nxt = 1'b0;
          sel_nxt       = cur_r;
          ins_prio_nxt  = cur_e_r.prio;
          idx_nxt       = count_r;
          requeue_nxt   = 1'b1;
          state_nxt     = S_INS_A;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        slot_re    = cur_valid_r;
        slot_raddr = cur_r;
        state_nxt  = S_OUT_WR;
      end
      // Hold until the result register is free, then load it.
      S_OUT_WR: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_rv_nxt      = cur_valid_r;
          o_rid_nxt     = cur_valid_r ? slot_rdata_r.ident : 8'd0;
          o_pre_nxt     = pre_r;
          o_dv_nxt      = dv_r;
          o_did_nxt     = did_r;
          o_dwait_nxt   = dwait_r;
          o_dresp_nxt   = dresp_r;
          o_dturn_nxt   = dturn_r;
          o_dpre_nxt    = dpre_r;
          if (act_r == ACT_TICK) clock_nxt = sat_add32(clock_r, {16'd0, tick_r});
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      head_r       <= '0;
      cur_r        <= '0;
      cur_valid_r  <= 1'b0;
      slice_used_r <= '0;
      clock_r      <= '0;
      slice_ms_r   <= SLICE_RESET;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      requeue_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) used_r[i] <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      cur_r        <= cur_nxt;
      cur_valid_r  <= cur_valid_nxt;
      slice_used_r <= slice_used_nxt;
      clock_r      <= clock_nxt;
      slice_ms_r   <= slice_ms_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      requeue_r    <= requeue_nxt;
      out_valid_r  <= out_valid_nxt;
      used_r       <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    act_r       <= act_nxt;
    id_r        <= id_nxt;
    prio_r      <= prio_nxt;
    pol_r       <= pol_nxt;
    burst_r     <= burst_nxt;
    tick_r      <= tick_nxt;
    sel_r       <= sel_nxt;
    ins_prio_r  <= ins_prio_nxt;
    cur_e_r     <= cur_e_nxt;
    status_r    <= status_nxt;
    pre_r       <= pre_nxt;
    dv_r        <= dv_nxt;
    did_r       <= did_nxt;
    dwait_r     <= dwait_nxt;
    dresp_r     <= dresp_nxt;
    dturn_r     <= dturn_nxt;
    dpre_r      <= dpre_nxt;
    o_status_r  <= o_status_nxt;
    o_rv_r      <= o_rv_nxt;
    o_rid_r     <= o_rid_nxt;
    o_pre_r     <= o_pre_nxt;
    o_dv_r      <= o_dv_nxt;
    o_did_r     <= o_did_nxt;
    o_dwait_r   <= o_dwait_nxt;
    o_dresp_r   <= o_dresp_nxt;
    o_dturn_r   <= o_dturn_nxt;
    o_dpre_r    <= o_dpre_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_running_valid    = o_rv_r;
  assign out_running_id       = o_rid_r;
  assign out_preempted        = o_pre_r;
  assign out_done_valid       = o_dv_r;
  assign out_done_id          = o_did_r;
  assign out_done_wait        = o_dwait_r;
  assign out_done_response    = o_dresp_r;
  assign out_done_turnaround  = o_dturn_r;
  assign out_done_preemptions = o_dpre_r;

endmodule
`default_nettype wire

// ===== hdl/ppts_checker.sv =====
// Port checker for the preemptive priority task scheduler, bound to the top level.
// Depends on ppts_pkg and the assertion macro header.
`default_nettype none
`include "priority_preemptive_task_scheduler_assert.svh"
module ppts_checker
  import ppts_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire        out_running_valid,
  input wire [7:0]  out_running_id,
  input wire        out_preempted,
  input wire        out_done_valid,
  input wire [7:0]  out_done_id,
  input wire [31:0] out_done_wait
);

  `PPTS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `PPTS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_status))
  `PPTS_ASSERT_OUT(a_done_zero, out_valid && !out_done_valid |-> (out_done_id == 8'd0) && (out_done_wait == 32'd0))
  `PPTS_ASSERT_OUT(a_idle_id, out_valid && !out_running_valid |-> out_running_id == 8'd0)
  `PPTS_ASSERT_OUT(a_full_quiet, out_valid && (out_status == ST_FULL) |-> !out_done_valid && !out_preempted)

endmodule

bind priority_preemptive_task_scheduler ppts_checker u_ppts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_running_valid (out_running_valid),
  .out_running_id    (out_running_id),
  .out_preempted     (out_preempted),
  .out_done_valid    (out_done_valid),
  .out_done_id       (out_done_id),
  .out_done_wait     (out_done_wait)
);
`default_nettype wire
